[design/hiff_pkg.sv]
// hiff_pkg: shared types and constants of the hierarchical if-and-only-if scorer.
// Used by hiff_level_cell, hiff_fitness_scorer and hiff_checker; depends on nothing.
package hiff_pkg;

    localparam int LEVELS_DEF     = 16;  // levels of the pairing chain
    localparam int VALUE_BITS_DEF = 8;   // allele bits taken into account
    localparam int ALLELE_W       = 8;   // allele field width on the port
    localparam int SCORE_W        = 20;  // width of each score field
    localparam int OUT_DATA_W     = 40;  // score_total + score_maximum, whole bytes

    // Pair formed in one level cell during the last cycle
    typedef struct packed {
        logic pair;   // two entries met at this level
        logic match;  // they were equal and not null
    } t_pair_evt;

endpackage

[design/hiff_level_cell.sv]
// hiff_level_cell: one level of the pairing chain, holding the pending entry.
// Depends on hiff_pkg for the pair event type.
module hiff_level_cell
    import hiff_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_tok_valid,
    input  logic [VALUE_BITS:0]   i_tok_value,   // top bit is the null mark
    output logic                  o_tok_valid,
    output logic [VALUE_BITS:0]   o_tok_value,
    output t_pair_evt             o_evt
);

    localparam logic [VALUE_BITS:0] NullValue = {1'b1, {VALUE_BITS{1'b0}}};

    logic                r_valid, n_valid;
    logic [VALUE_BITS:0] r_value, n_value;
    logic                r_up_valid, n_up_valid;
    logic [VALUE_BITS:0] r_up_value, n_up_value;
    t_pair_evt           r_evt, n_evt;

    always_comb begin
        n_valid    = r_valid;
        n_value    = r_value;
        n_up_valid = 1'b0;
        n_up_value = r_up_value;
        n_evt      = '0;
        if (i_clear) begin
            n_valid = 1'b0;
        end else if (i_tok_valid) begin
            if (!r_valid) begin
                n_valid = 1'b1;
                n_value = i_tok_value;
            end else begin
                n_valid     = 1'b0;
                n_evt.pair  = 1'b1;
                n_evt.match = (r_value == i_tok_value) && !i_tok_value[VALUE_BITS];
                n_up_valid  = 1'b1;
                n_up_value  = n_evt.match ? i_tok_value : NullValue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_up_valid <= 1'b0;
            r_evt      <= '0;
        end else begin
            r_valid    <= n_valid;
            r_up_valid <= n_up_valid;
            r_evt      <= n_evt;
        end
        r_value    <= n_value;
        r_up_value <= n_up_value;
    end

    assign o_tok_valid = r_up_valid;
    assign o_tok_value = r_up_value;
    assign o_evt       = r_evt;

endmodule

[design/hiff_fitness_scorer.sv]
// hiff_fitness_scorer: top level of the hierarchical if-and-only-if fitness scorer.
// Depends on hiff_pkg and instantiates one hiff_level_cell per level.
//
// Alleles arrive one per transfer on the slave stream, tlast marking the final
// allele of a solution. Each allele becomes a token that climbs a chain of
// LEVELS cells, one cell per clock: a cell that is empty keeps the token, a
// cell that already holds an entry forms a pair, reports it and hands the
// merged value (or a null) to the next cell. A pair at level k weighs 2^k; its
// weight always goes into the maximum and, when both entries match and are
// not null, into the total. Entries left unpaired at the end are dropped.
// One allele is in flight at a time: the next transfer is taken only once the
// previous allele is done, whether it injected no token (after overflow), its
// token stayed at level 0 or it climbed the whole chain, the token walking the
// cell chain one level per clock. A tlast allele also waits
// for as long as the previous result is still unread. After the
// allele flagged tlast has finished its walk, one result transfer carries
// score_total and score_maximum (each saturated at 2^20-1) with the overflow
// flag in tuser, and all state clears. The result sits in an output register,
// so a new solution may start while the result waits. Alleles beyond 2^LEVELS
// in one solution are ignored and set overflow. The ratio total/maximum is
// left to software.
module hiff_fitness_scorer
    import hiff_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream: alleles
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [ALLELE_W-1:0]   i_s_tdata,   // [7:0] allele
    input  logic                  i_s_tlast,   // last allele of the solution
    // master stream: scores
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [19:0] score_total, [39:20] score_maximum
    output logic                  o_m_tuser    // [0] overflow
);

    // Accumulator width: the maximum can reach LEVELS * 2^(LEVELS-1)
    localparam int AccRaw = LEVELS + $clog2(LEVELS) + 1;
    localparam int AccW   = (AccRaw > SCORE_W + 1) ? AccRaw : SCORE_W + 1;

    // Token chain: index 0 feeds level 0, index LEVELS leaves the top cell
    logic [LEVELS:0]     w_tok_valid;
    logic [VALUE_BITS:0] w_tok_value [LEVELS+1];
    t_pair_evt           w_evt       [LEVELS];
    logic [LEVELS-1:0]   w_pair_vec;
    logic [LEVELS-1:0]   w_match_vec;

    logic                r_tok_valid;
    logic [VALUE_BITS:0] r_tok_value;
    logic                r_busy, n_busy;
    logic                r_last;
    logic                r_root_done;
    logic                r_overflow;
    logic [AccW-1:0]     r_total;
    logic [AccW-1:0]     r_maximum;
    logic                r_out_valid, n_out_valid;
    logic [SCORE_W-1:0]  r_out_total;
    logic [SCORE_W-1:0]  r_out_maximum;
    logic                r_out_overflow;

    logic w_accept;
    logic w_walk_active;
    logic w_finish;

    assign w_accept = i_s_tvalid && o_s_tready;

    assign w_tok_valid[0] = r_tok_valid;
    assign w_tok_value[0] = r_tok_value;

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_level
            hiff_level_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_clear     (w_finish),
                .i_tok_valid (w_tok_valid[g]),
                .i_tok_value (w_tok_value[g]),
                .o_tok_valid (w_tok_valid[g+1]),
                .o_tok_value (w_tok_value[g+1]),
                .o_evt       (w_evt[g])
            );
            // only one cell pairs per cycle, so the bit vector is the weight
            assign w_pair_vec[g]  = w_evt[g].pair;
            assign w_match_vec[g] = w_evt[g].match;
        end
    endgenerate

    // Token still climbing, or a pair still to be summed
    assign w_walk_active = (|w_tok_valid) || (|w_pair_vec);

    // Walk over; last allele's result loads once the output register is free
    always_comb begin
        n_busy   = r_busy;
        w_finish = 1'b0;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (r_busy && !w_walk_active) begin
            if (!r_last) begin
                n_busy = 1'b0;
            end else if (!r_out_valid || i_m_tready) begin
                n_busy   = 1'b0;
                w_finish = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tok_valid <= 1'b0;
            r_last      <= 1'b0;
            r_root_done <= 1'b0;
            r_overflow  <= 1'b0;
            r_total     <= '0;
            r_maximum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            // overflowing alleles inject no token
            r_tok_valid <= w_accept && !r_root_done;
            if (w_accept) begin
                r_last <= i_s_tlast;
            end
            if (w_finish) begin
                r_root_done <= 1'b0;
                r_overflow  <= 1'b0;
                r_total     <= '0;
                r_maximum   <= '0;
            end else begin
                if (w_tok_valid[LEVELS]) begin
                    r_root_done <= 1'b1;
                end
                if (w_accept && r_root_done) begin
                    r_overflow <= 1'b1;
                end
                r_total   <= r_total + AccW'(w_match_vec);
                r_maximum <= r_maximum + AccW'(w_pair_vec);
            end
        end
        if (w_accept) begin
            r_tok_value <= {1'b0, VALUE_BITS'(i_s_tdata)};
        end
        if (w_finish) begin
            r_out_total    <= (|r_total[AccW-1:SCORE_W])   ? '1 : r_total[SCORE_W-1:0];
            r_out_maximum  <= (|r_maximum[AccW-1:SCORE_W]) ? '1 : r_maximum[SCORE_W-1:0];
            r_out_overflow <= r_overflow;
        end
    end

    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_maximum, r_out_total};
    assign o_m_tuser  = r_out_overflow;

endmodule

[design/hiff_checker.sv]
// hiff_checker: port-level assertions for hiff_fitness_scorer, with its bind.
// Depends on hiff_pkg for port widths.
module hiff_checker
    import hiff_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  o_s_tready,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  o_m_tuser
);

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // one allele at a time: busy right after each transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("allele taken while previous one still climbing");

    // matching pairs are a subset of all pairs
    a_total_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[SCORE_W-1:0] <= o_m_tdata[2*SCORE_W-1:SCORE_W])
        else $error("total exceeds maximum");

endmodule

bind hiff_fitness_scorer hiff_checker u_hiff_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
